>>> src/oal_pkg.sv
// oal_pkg: sizes, operation and status codes, cell control struct
// shared by the ordered array list engine and its cells; no dependencies
`timescale 1ns / 1ps

package oal_pkg;

  localparam int DEPTH      = 64;
  localparam int ELEM_WIDTH = 32;

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 7;
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    FN_PUSH_BACK  = 3'd0,
    FN_PUSH_FRONT = 3'd1,
    FN_POP_BACK   = 3'd2,
    FN_POP_FRONT  = 3'd3,
    FN_INSERT     = 3'd4,
    FN_ERASE      = 3'd5,
    FN_FIND       = 3'd6
  } func_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_OPEN  = 2'd1,
    CELL_CLOSE = 2'd2,
    CELL_FIND  = 2'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t              cmd;
    logic [CMP_W-1:0]       pos;
    logic [CNT_W-1:0]       count;
    logic [ELEM_WIDTH-1:0]  value;
  } cell_ctl_t;

endpackage

>>> src/oal_cell.sv
// oal_cell: one list slot; shifts with its neighbors and compares for find
// depends on oal_pkg
`timescale 1ns / 1ps

module oal_cell (
  input  logic                          clk,
  input  oal_pkg::cell_ctl_t            ctl,
  input  logic [oal_pkg::IDX_W-1:0]     idx,
  input  logic [oal_pkg::ELEM_WIDTH-1:0] lower_data,
  input  logic [oal_pkg::ELEM_WIDTH-1:0] upper_data,
  output logic [oal_pkg::ELEM_WIDTH-1:0] data,
  output logic                          match
);
  import oal_pkg::*;

  logic [ELEM_WIDTH-1:0] data_r;
  logic [ELEM_WIDTH-1:0] data_nxt;
  logic                  match_r;
  logic [CMP_W-1:0]      idx_ext;

  assign idx_ext = CMP_W'(idx);

  always_comb begin
    data_nxt = data_r;
    case (ctl.cmd)
      CELL_OPEN: begin
        if (idx_ext > ctl.pos) data_nxt = lower_data;
        else if (idx_ext == ctl.pos) data_nxt = ctl.value;
      end
      CELL_CLOSE: begin
        if (idx_ext >= ctl.pos) data_nxt = upper_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= (ctl.cmd == CELL_FIND) && (CNT_W'(idx) < ctl.count) &&
               (data_r == ctl.value);
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

>>> src/oal_prio_enc.sv
// oal_prio_enc: lowest set bit of the registered cell match row
// depends on oal_pkg
`timescale 1ns / 1ps

module oal_prio_enc (
  input  logic [oal_pkg::DEPTH-1:0] match_vec,
  output logic                      any,
  output logic [oal_pkg::IDX_W-1:0] first_idx
);
  import oal_pkg::*;

  always_comb begin
    first_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_vec[i]) first_idx = IDX_W'(i);
    end
  end

  assign any = |match_vec;

endmodule

>>> src/ordered_array_list_engine.sv
// ordered_array_list_engine: top level, request decode, cell row, result register
// depends on oal_pkg, oal_cell, oal_prio_enc
`timescale 1ns / 1ps

// A packed list of up to DEPTH signed words held in a row of cells, one word
// per cell. Push, pop, insert and erase finish in the cycle of the input
// transfer: every cell at or past the position takes its neighbor's word or
// the new word in the same clock, and the result (status, found index 0, new
// count) is registered with it. Find has every cell compare its word and
// register a match bit; in the following cycle a priority encoder over the
// match row picks the lowest index. So one request per cycle is taken for
// everything but find while in_stall is low. in_stall is raised in a find's
// encoder cycle and whenever a result waits in the output register under
// out_stall; a result leaving in the same cycle frees the register for the
// next transfer. Entries need no clearing after reset: only indices below
// the count are ever compared.
module ordered_array_list_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [6:0]  in_position,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [5:0]  out_found_index,
  output logic [6:0]  out_count
);
  import oal_pkg::*;

  // control state
  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;

  // result payload
  status_t          out_status_r, out_status_nxt;
  logic [IDX_W-1:0] out_found_r, out_found_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  logic             in_xfer;
  logic             out_xfer;
  func_t            func;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             full;
  logic             empty;
  status_t          req_status;
  cell_ctl_t        ctl;

  logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]      match_vec;
  logic                  match_any;
  logic [IDX_W-1:0]      match_idx;

  assign in_stall = busy_r | (out_valid_r & out_stall);
  assign in_xfer  = in_valid & ~in_stall;
  assign out_xfer = out_valid_r & ~out_stall;

  assign func    = func_t'(in_func);
  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);

  // request decode: cell command, new count and status
  always_comb begin
    ctl.cmd    = CELL_HOLD;
    ctl.pos    = '0;
    ctl.count  = count_r;
    ctl.value  = ELEM_WIDTH'({32'd0, in_value});
    count_nxt  = count_r;
    req_status = ST_OK;
    busy_nxt   = 1'b0;
    if (in_xfer) begin
      case (func)
        FN_PUSH_BACK, FN_PUSH_FRONT: begin
          if (full) begin
            req_status = ST_FULL;
          end else begin
            ctl.cmd   = CELL_OPEN;
            ctl.pos   = (func == FN_PUSH_BACK) ? cnt_ext : '0;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        FN_POP_BACK: begin
          if (empty) req_status = ST_EMPTY;
          else count_nxt = count_r - CNT_W'(1);
        end
        FN_POP_FRONT: begin
          if (empty) begin
            req_status = ST_EMPTY;
          end else begin
            ctl.cmd   = CELL_CLOSE;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        FN_INSERT: begin
          if (full) begin
            req_status = ST_FULL;
          end else if (pos_ext > cnt_ext) begin
            req_status = ST_BADPOS;
          end else begin
            ctl.cmd   = CELL_OPEN;
            ctl.pos   = pos_ext;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        FN_ERASE: begin
          if (empty) begin
            req_status = ST_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            req_status = ST_BADPOS;
          end else begin
            ctl.cmd   = CELL_CLOSE;
            ctl.pos   = pos_ext;
            count_nxt = count_r - CNT_W'(1);
          end
        end
        FN_FIND: begin
          // cells compare now, encoder answers next cycle
          ctl.cmd  = CELL_FIND;
          busy_nxt = 1'b1;
        end
        default: req_status = ST_OK;
      endcase
    end
  end

  // result register: filled by a finished request, emptied by an out transfer
  always_comb begin
    out_valid_nxt  = out_valid_r & ~out_xfer;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    if (busy_r) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = match_any ? ST_OK : ST_NOTFOUND;
      out_found_nxt  = match_any ? match_idx : '0;
      out_count_nxt  = count_r;
    end else if (in_xfer && (func != FN_FIND)) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = req_status;
      out_found_nxt  = '0;
      out_count_nxt  = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
  end

  // row of cells, each linked to its lower and upper neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] lower_w;
    logic [ELEM_WIDTH-1:0] upper_w;
    if (i == 0) begin : g_first
      assign lower_w = '0;
    end else begin : g_lower
      assign lower_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper_w = '0;
    end else begin : g_upper
      assign upper_w = cell_data[i+1];
    end
    oal_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (IDX_W'(i)),
      .lower_data (lower_w),
      .upper_data (upper_w),
      .data       (cell_data[i]),
      .match      (match_vec[i])
    );
  end

  oal_prio_enc u_enc (
    .match_vec (match_vec),
    .any       (match_any),
    .first_idx (match_idx)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = 6'(out_found_r);
  assign out_count       = 7'(out_count_r);

endmodule

>>> src/oal_checker.sv
// oal_checker: port-level assertions for the ordered array list engine
// depends on oal_pkg; bound to ordered_array_list_engine below
`timescale 1ns / 1ps

module oal_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_status,
  input logic [5:0] out_found_index,
  input logic [6:0] out_count
);
  import oal_pkg::*;

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_found_index) && $stable(out_count))
    else $error("result changed while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_count == 7'(DEPTH)))
    else $error("full status with count below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_count == 7'd0))
    else $error("empty status with nonzero count");

  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_found_index == 6'd0))
    else $error("found index set on failed request");

endmodule

bind ordered_array_list_engine oal_checker u_oal_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_found_index (out_found_index),
  .out_count       (out_count)
);

>>> test/tb_ordered_array_list_engine.sv
// tb_ordered_array_list_engine: self-checking testbench for the ordered array list engine
// drives requests over valid/stall, predicts every reply and checks it field by field
// depends on oal_pkg and ordered_array_list_engine
`timescale 1ns / 1ps

module tb_ordered_array_list_engine;
  import oal_pkg::*;

  // func code 7 selects no operation, the block answers ok and leaves the list alone
  localparam logic [2:0] FN_UNUSED = 3'd7;

  localparam int  CLK_PERIOD = 20;
  localparam int  LONG_HOLD  = 60;            // receiver hold-off for the back-pressure test
  localparam int  DRAIN_WAIT = 10;            // cycles after the last reply before the verdict
  localparam longint WATCHDOG_NS = 64'd5_000_000;

  // one reply as the list produces it
  typedef struct {
    status_t    status;
    logic [5:0] found_index;
    logic [6:0] count;
  } list_reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_func;
  logic [6:0]  in_position;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [5:0]  out_found_index;
  logic [6:0]  out_count;

  // shadow copy of the list, updated once per accepted request
  logic [31:0] list_words [DEPTH];
  int          list_len;

  // replies predicted but not yet seen on the output
  list_reply_t pending_replies [$];

  // knobs shared by the stimulus and the receiver
  bit tx_bursts;
  bit rx_bursts;
  bit hold_request;

  // run statistics
  int error_count;
  int requests_sent;
  int find_hits;
  int longest_list;
  int full_replies;
  int blocked_offers;

  ordered_array_list_engine DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_found_index (out_found_index),
    .out_count       (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // applies one request to the shadow list and returns the reply it must give
  function automatic list_reply_t apply_request(input logic [2:0] op, input logic [6:0] pos,
                                                input logic [31:0] val);
    list_reply_t r;
    int at;
    r.status      = ST_OK;
    r.found_index = '0;
    case (op)
      FN_PUSH_BACK, FN_PUSH_FRONT, FN_INSERT: begin
        at = (op == FN_PUSH_BACK) ? list_len : (op == FN_PUSH_FRONT) ? 0 : int'(pos);
        // full wins over a bad position
        if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else if (at > list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = list_len; i > at; i--) list_words[i] = list_words[i-1];
          list_words[at] = val;
          list_len++;
        end
      end
      FN_POP_BACK, FN_POP_FRONT, FN_ERASE: begin
        at = (op == FN_POP_BACK) ? list_len - 1 : (op == FN_POP_FRONT) ? 0 : int'(pos);
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (at >= list_len) begin
          r.status = ST_BADPOS;
        end else begin
          for (int i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      FN_FIND: begin
        // walk down so the lowest matching index is the one kept
        r.status = ST_NOTFOUND;
        for (int i = list_len - 1; i >= 0; i--) begin
          if (list_words[i] == val) begin
            r.status      = ST_OK;
            r.found_index = i[5:0];
          end
        end
      end
      default: ;
    endcase
    r.count = list_len[6:0];
    return r;
  endfunction

  // value to store or look up: often one already in the list, some corner words
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30 && list_len > 0) return list_words[$urandom_range(0, list_len - 1)];
    if (r < 42) begin
      case ($urandom_range(0, 4))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'h0000_0000;
        3:       return 32'hffff_ffff;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom();
  endfunction

  // offers one request, waits for its transfer and records the expected reply
  task automatic send_item(input logic [2:0] op, input logic [6:0] pos, input logic [31:0] val);
    list_reply_t reply;
    int gap;
    // optional idle burst ahead of the request
    if (tx_bursts && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_func     <= op;
    in_position <= pos;
    in_value    <= val;
    // payload stays put until the transfer
    do @(posedge clk); while (in_stall !== 1'b0);
    reply = apply_request(op, pos, val);
    pending_replies.push_back(reply);
    requests_sent++;
    if (op == FN_FIND && reply.status == ST_OK) find_hits++;
    if (reply.status == ST_FULL) full_replies++;
    if (list_len > longest_list) longest_list = list_len;
  endtask

  // empty-list answers, bad positions, append by insert, extremes of the value
  task automatic test_empty_and_edges();
    send_item(FN_POP_BACK, 7'd0, 32'h0);
    send_item(FN_POP_FRONT, 7'd0, 32'h0);
    send_item(FN_ERASE, 7'd0, 32'h0);
    send_item(FN_FIND, 7'd0, 32'h0);            // nothing to find on an empty list
    send_item(FN_UNUSED, 7'd127, 32'hffff_ffff);
    send_item(FN_INSERT, 7'd1, 32'h1234_5678);  // past the count
    send_item(FN_INSERT, 7'd0, 32'h8000_0000);
    send_item(FN_PUSH_BACK, 7'd0, 32'h7fff_ffff);
    send_item(FN_PUSH_FRONT, 7'd0, 32'hffff_ffff);
    send_item(FN_PUSH_BACK, 7'd0, 32'h0000_0000);
    send_item(FN_FIND, 7'd0, 32'h7fff_ffff);
    send_item(FN_FIND, 7'd0, 32'h8000_0000);
    send_item(FN_ERASE, 7'd127, 32'h0);
    send_item(FN_ERASE, 7'd4, 32'h0);           // one past the last entry
    send_item(FN_INSERT, 7'd4, 32'hffff_ffff);  // insert at the count appends
    send_item(FN_FIND, 7'd0, 32'hffff_ffff);    // duplicate, first index wins
    send_item(FN_FIND, 7'd0, 32'h5555_aaaa);
    send_item(FN_UNUSED, 7'd3, 32'h0);
    send_item(FN_POP_BACK, 7'd0, 32'h0);
    send_item(FN_POP_FRONT, 7'd0, 32'h0);
    send_item(FN_ERASE, 7'd1, 32'h0);
  endtask

  // fill to capacity, then every full answer and work at the top index
  task automatic test_full_list();
    while (list_len < DEPTH) begin
      case ($urandom_range(0, 2))
        0:       send_item(FN_PUSH_BACK, 7'($urandom_range(0, 127)), $urandom());
        1:       send_item(FN_PUSH_FRONT, 7'($urandom_range(0, 127)), $urandom());
        default: send_item(FN_INSERT, 7'($urandom_range(0, list_len)), $urandom());
      endcase
    end
    send_item(FN_PUSH_BACK, 7'd0, 32'h1);
    send_item(FN_PUSH_FRONT, 7'd0, 32'h1);
    send_item(FN_INSERT, 7'd127, 32'h1);        // full beats bad position
    send_item(FN_FIND, 7'd0, list_words[DEPTH-1]);
    send_item(FN_ERASE, 7'd64, 32'h0);
    send_item(FN_ERASE, 7'd63, 32'h0);
    send_item(FN_INSERT, 7'd63, 32'h8000_0000);
    send_item(FN_FIND, 7'd0, 32'h8000_0000);
    send_item(FN_POP_FRONT, 7'd0, 32'h0);
    send_item(FN_POP_BACK, 7'd0, 32'h0);
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_back_pressure();
    hold_request = 1'b1;
    repeat (40) send_item(3'($urandom_range(0, 6)), 7'($urandom_range(0, list_len)),
                          pick_value());
  endtask

  // random traffic; grow_pct steers the list length up or down
  task automatic test_random_traffic(input int n_items, input int grow_pct);
    logic [2:0] op;
    logic [6:0] pos;
    int r;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        op = FN_FIND;
      end else if (r < 27) begin
        op = FN_UNUSED;
      end else if ($urandom_range(0, 99) < grow_pct) begin
        case ($urandom_range(0, 2))
          0:       op = FN_PUSH_BACK;
          1:       op = FN_PUSH_FRONT;
          default: op = FN_INSERT;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       op = FN_POP_BACK;
          1:       op = FN_POP_FRONT;
          default: op = FN_ERASE;
        endcase
      end
      // mostly legal positions, now and then anything the field can hold
      if ($urandom_range(0, 99) < 85) pos = 7'($urandom_range(0, list_len));
      else pos = 7'($urandom_range(0, 127));
      send_item(op, pos, pick_value());
    end
  endtask

  // receiver side: random stall bursts plus the long hold-off on request
  initial begin : receiver
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst_left > 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (rx_bursts && $urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(1, 7) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // every reply transfer is matched against the oldest prediction
  always @(posedge clk) begin : reply_check
    list_reply_t want;
    if (rst_n) begin
      if (in_valid && in_stall === 1'b1) blocked_offers++;
      if (out_valid && !out_stall) begin
        if (pending_replies.size() == 0) begin
          $error("reply with no request outstanding: status %0d count %0d",
                 out_status, out_count);
          error_count++;
        end else begin
          want = pending_replies.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            error_count++;
          end
          if (out_found_index !== want.found_index) begin
            $error("found_index: expected %0d, actual %0d", want.found_index, out_found_index);
            error_count++;
          end
          if (out_count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, out_count);
            error_count++;
          end
        end
      end
    end
  end

  // hard stop in case the block hangs
  initial begin : watchdog
    #(WATCHDOG_NS);
    $error("timeout with %0d replies outstanding", pending_replies.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : main_sequence
    int grow_steps [6] = '{70, 30, 60, 20, 85, 50};
    // every input known from time zero
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_func      = FN_PUSH_BACK;
    in_position  = '0;
    in_value     = '0;
    tx_bursts    = 1'b0;
    rx_bursts    = 1'b0;
    hold_request = 1'b0;
    error_count  = 0;
    requests_sent  = 0;
    find_hits      = 0;
    longest_list   = 0;
    full_replies   = 0;
    blocked_offers = 0;
    list_len       = 0;

    // synchronous reset, released at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_bursts = 1'b1;
    rx_bursts = 1'b1;
    test_empty_and_edges();
    test_full_list();
    test_back_pressure();

    // random segments, every other one with both sides running flat out
    for (int seg = 0; seg < 6; seg++) begin
      tx_bursts = (seg % 2 == 0);
      rx_bursts = (seg % 2 == 0);
      test_random_traffic(250, grow_steps[seg]);
    end

    // closing stretch at full rate, no idling anywhere
    tx_bursts = 1'b0;
    rx_bursts = 1'b0;
    test_random_traffic(250, 50);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d requests: %0d find hits, %0d full answers, list length up to %0d",
             requests_sent, find_hits, full_replies, longest_list);
    $display("Input held off for %0d offered cycles", blocked_offers);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/oal_pkg.sv
src/oal_cell.sv
src/oal_prio_enc.sv
src/ordered_array_list_engine.sv
src/oal_checker.sv
test/tb_ordered_array_list_engine.sv
